/* sv/dfa_pkg.sv */
// Package for the DFA word recognizer: table geometry, command and
// operation codes, item and status structs.
// No dependencies.
package dfa_pkg;

	localparam int NUM_STATES  = 16;
	localparam int SYMBOL_BITS = 8;
	localparam int STATE_W     = $clog2(NUM_STATES);
	localparam int TBL_DEPTH   = NUM_STATES << SYMBOL_BITS;
	localparam int TBL_AW      = $clog2(TBL_DEPTH);
	localparam int MASK_W      = 16;

	localparam logic REG_START = 1'b0;
	localparam logic REG_MASK  = 1'b1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_FEED  = 2'd1,
		CMD_END   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_FEED,
		OP_END
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [STATE_W-1:0]     from_state;
		logic [STATE_W-1:0]     to_state;
		logic [SYMBOL_BITS-1:0] symbol;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic               valid;
		logic [STATE_W-1:0] dest;
	} entry_t;

	typedef struct packed {
		logic               valid;
		logic [STATE_W-1:0] state;
	} restart_t;

	typedef struct packed {
		logic               clearing;
		logic [STATE_W-1:0] cur_state;
	} back_status_t;

endpackage

/* sv/dfa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/dfa_front.sv */
// Front end: accepts items, classifies commands, drops unused ones and
// holds them in a four-entry queue for the back end. Uses dfa_pkg.
module dfa_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [1:0]                      cmd,
	input  logic [dfa_pkg::STATE_W-1:0]     from_state,
	input  logic [dfa_pkg::STATE_W-1:0]     to_state,
	input  logic [dfa_pkg::SYMBOL_BITS-1:0] symbol,
	output logic                            full,
	input  logic                            hold,
	input  logic                            take,
	output dfa_pkg::head_t                  head
);
	import dfa_pkg::*;

	localparam int QD = 4;
	localparam int QAW = $clog2(QD);

	item_t          q_q [QD];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;
	logic           accept;
	logic           enq;
	logic           deq;
	item_t          cls;

	assign full   = (cnt_q == (QAW+1)'(QD)) || hold;
	assign accept = push && !full;

	always_comb begin
		cls.from_state = from_state;
		cls.to_state   = to_state;
		cls.symbol     = symbol;
		cls.op         = OP_WRITE;
		enq            = 1'b0;
		case (cmd)
			CMD_WRITE: begin
				cls.op = OP_WRITE;
				enq    = accept;
			end
			CMD_FEED: begin
				cls.op = OP_FEED;
				enq    = accept;
			end
			CMD_END: begin
				cls.op = OP_END;
				enq    = accept;
			end
			default: begin
				enq = 1'b0;
			end
		endcase
	end

	assign head.valid = (cnt_q != '0);
	assign head.item  = q_q[rp_q];
	assign deq        = take && head.valid;

	always_ff @(posedge clk) begin
		if (enq) begin
			q_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wp_q <= wp_q + QAW'(1);
			end
			if (deq) begin
				rp_q <= rp_q + QAW'(1);
			end
			case ({enq, deq})
				2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/dfa_back.sv */
// Back end: clears the transition table after reset, writes transitions,
// steps the automaton with at most one table read per symbol, queues verdicts.
// Uses dfa_pkg and dfa_ram.
module dfa_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dfa_pkg::head_t              head,
	output logic                        take,
	input  logic [dfa_pkg::STATE_W-1:0] start_state,
	input  logic [dfa_pkg::MASK_W-1:0]  accepting_mask,
	input  dfa_pkg::restart_t           restart,
	input  logic                        pop,
	output logic                        empty,
	output logic                        accepted,
	output dfa_pkg::back_status_t       status
);
	import dfa_pkg::*;

	logic                clr_q;
	logic [TBL_AW-1:0]   clr_addr_q;
	logic [STATE_W-1:0]  cur_q;
	logic                dead_q;
	logic                rd_pend_q;
	entry_t              rd_entry;
	logic [STATE_W-1:0]  cur_eff;
	logic                dead_eff;
	logic                we;
	logic [TBL_AW-1:0]   waddr;
	entry_t              wentry;
	logic                re;
	logic [TBL_AW-1:0]   raddr;
	logic                is_end;
	logic                verdict;
	logic                o_q [2];
	logic                owp_q;
	logic                orp_q;
	logic [1:0]          ocnt_q;
	logic                ofull;
	logic                opush;
	logic                opop;

	assign cur_eff  = (rd_pend_q && rd_entry.valid) ? rd_entry.dest : cur_q;
	assign dead_eff = dead_q || (rd_pend_q && !rd_entry.valid);

	assign ofull  = (ocnt_q == 2'd2);
	assign is_end = (head.item.op == OP_END);
	assign take   = head.valid && !clr_q && !(is_end && ofull);

	assign we     = clr_q || (take && head.item.op == OP_WRITE);
	assign waddr  = clr_q ? clr_addr_q : {head.item.from_state, head.item.symbol};
	assign wentry = clr_q ? entry_t'('0) : entry_t'{valid: 1'b1, dest: head.item.to_state};
	assign re     = take && head.item.op == OP_FEED && !dead_eff;
	assign raddr  = {cur_eff, head.item.symbol};

	assign verdict = !dead_eff && accepting_mask[cur_eff];
	assign opush   = take && is_end;
	assign opop    = pop && !empty;

	dfa_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TBL_DEPTH)
	) u_tbl (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wentry),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + TBL_AW'(1);
			if (clr_addr_q == '1) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			dead_q    <= 1'b0;
			rd_pend_q <= 1'b0;
		end else if (restart.valid) begin
			cur_q     <= restart.state;
			dead_q    <= 1'b0;
			rd_pend_q <= 1'b0;
		end else if (opush) begin
			cur_q     <= start_state;
			dead_q    <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			cur_q     <= cur_eff;
			dead_q    <= dead_eff;
			rd_pend_q <= re;
		end
	end

	always_ff @(posedge clk) begin
		if (opush) begin
			o_q[owp_q] <= verdict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (opush) begin
				owp_q <= !owp_q;
			end
			if (opop) begin
				orp_q <= !orp_q;
			end
			case ({opush, opop})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	assign empty    = (ocnt_q == 2'd0);
	assign accepted = o_q[orp_q];

	assign status.clearing  = clr_q;
	assign status.cur_state = cur_q;

endmodule

/* sv/dfa_word_recognizer.sv */
// Top level of the DFA word recognizer: APB registers, front end, back end.
// Uses dfa_pkg, dfa_front, dfa_back.
// Throughput: one item per cycle while full is low; a fed symbol needs one table read, whose
// registered data steers the next read address directly.
// Results: a verdict is registered in the verdict queue when the back end takes its end item.
// Reset: the 4096-entry table is cleared for 4096 cycles; full stays high meanwhile.
module dfa_word_recognizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      cmd,
	input  logic [dfa_pkg::STATE_W-1:0]     from_state,
	input  logic [dfa_pkg::STATE_W-1:0]     to_state,
	input  logic [dfa_pkg::SYMBOL_BITS-1:0] symbol,
	output logic                            empty,
	input  logic                            pop,
	output logic                            accepted,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import dfa_pkg::*;

	logic [STATE_W-1:0] start_q;
	logic [MASK_W-1:0]  mask_q;
	logic               cfg_wr;
	restart_t           restart;
	head_t              head;
	logic               take;
	back_status_t       status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			mask_q  <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_START: start_q <= pwdata[STATE_W-1:0];
				REG_MASK:  mask_q  <= pwdata[MASK_W-1:0];
				default:   mask_q  <= mask_q;
			endcase
		end
	end

	assign restart.valid = cfg_wr && (paddr[2] == REG_START);
	assign restart.state = pwdata[STATE_W-1:0];

	assign prdata = (paddr[2] == REG_MASK) ? {{(32-MASK_W){1'b0}}, mask_q}
	                                       : {{(32-STATE_W){1'b0}}, start_q};

	dfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd       (cmd),
		.from_state(from_state),
		.to_state  (to_state),
		.symbol    (symbol),
		.full      (full),
		.hold      (status.clearing),
		.take      (take),
		.head      (head)
	);

	dfa_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.take          (take),
		.start_state   (start_q),
		.accepting_mask(mask_q),
		.restart       (restart),
		.pop           (pop),
		.empty         (empty),
		.accepted      (accepted),
		.status        (status)
	);

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> full)
		else $error("input open during table clear");

	a_clear_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> empty)
		else $error("result present during table clear");

	a_restart_loads_start: assert property (@(posedge clk) disable iff (!arst_n)
		restart.valid |=> status.cur_state == $past(pwdata[STATE_W-1:0]))
		else $error("start write did not restart the word");

endmodule

/* bench/dfa_word_recognizer_test.sv */
// Testbench for dfa_word_recognizer. It programs transition tables, feeds words and checks
// every verdict against an in-bench automaton. Idling and back-pressure are random but for
// test_no_idle, which turns both off. Depends on dfa_pkg and the dfa_word_recognizer RTL.
module dfa_word_recognizer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dfa_pkg::*;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int         QUIET_CYCLES = 8;
	localparam int         STALL_LIMIT  = 12000;
	localparam int         MAX_REPORTS  = 40;

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	logic [1:0]             cmd;
	logic [STATE_W-1:0]     from_state;
	logic [STATE_W-1:0]     to_state;
	logic [SYMBOL_BITS-1:0] symbol;
	logic                   empty;
	logic                   pop;
	logic                   accepted;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [2:0]             paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;

	logic                   trans_valid [TBL_DEPTH];
	logic [STATE_W-1:0]     trans_dest [TBL_DEPTH];
	logic [STATE_W-1:0]     cur_state;
	logic [STATE_W-1:0]     start_reg;
	logic [MASK_W-1:0]      mask_reg;
	logic                   word_dead;
	logic                   verdict_q [$];
	logic [SYMBOL_BITS-1:0] known_syms [NUM_STATES][$];

	int mismatch_count = 0;
	int sink_hold      = 0;
	bit src_idle_en    = 1'b1;
	bit sink_idle_en   = 1'b1;

	dfa_word_recognizer dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string what);
		if (mismatch_count < MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic logic [STATE_W-1:0] rand_state();
		return STATE_W'($urandom_range(0, NUM_STATES - 1));
	endfunction

	function automatic logic [SYMBOL_BITS-1:0] rand_symbol();
		return SYMBOL_BITS'($urandom_range(0, (1 << SYMBOL_BITS) - 1));
	endfunction

	function automatic void advance_dfa(logic [1:0] c, logic [STATE_W-1:0] f,
			logic [STATE_W-1:0] t, logic [SYMBOL_BITS-1:0] s);
		logic [TBL_AW-1:0] idx;
		case (c)
		CMD_WRITE: begin
			idx = {f, s};
			trans_valid[idx] = 1'b1;
			trans_dest[idx]  = t;
		end
		CMD_FEED: begin
			if (!word_dead) begin
				idx = {cur_state, s};
				if (trans_valid[idx])
					cur_state = trans_dest[idx];
				else
					word_dead = 1'b1;
			end
		end
		CMD_END: begin
			verdict_q.push_back(!word_dead && mask_reg[cur_state]);
			cur_state = start_reg;
			word_dead = 1'b0;
		end
		default: ;
		endcase
	endfunction

	task automatic send_item(logic [1:0] c, logic [STATE_W-1:0] f, logic [STATE_W-1:0] t,
			logic [SYMBOL_BITS-1:0] s);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		push       <= 1'b1;
		cmd        <= c;
		from_state <= f;
		to_state   <= t;
		symbol     <= s;
		do @(posedge clk); while (full);
		advance_dfa(c, f, t, s);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic reg_sel, logic [31:0] data);
		logic [31:0] want;
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (reg_sel == REG_START) begin
			start_reg = data[STATE_W-1:0];
			cur_state = start_reg;
			word_dead = 1'b0;
		end else begin
			mask_reg = data[MASK_W-1:0];
		end
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		want = (reg_sel == REG_START) ? 32'(start_reg) : 32'(mask_reg);
		if (prdata !== want)
			report_mismatch($sformatf("register %0d reads %h, expected %h",
				reg_sel, prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin : check_verdicts
		logic want;
		if (arst_n && pop && !empty) begin
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("verdict %b with none expected", accepted));
			end else begin
				want = verdict_q.pop_front();
				if (accepted !== want)
					report_mismatch($sformatf("accepted %b, expected %b", accepted, want));
			end
		end
	end

	initial begin : drive_pop
		int stall_left;
		stall_left = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				sink_hold--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 14);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	task automatic test_reset_values();
		send_item(CMD_END, 4'd0, 4'd0, 8'd0);
		send_item(CMD_FEED, 4'd0, 4'd0, 8'h5A);
		send_item(CMD_END, 4'd0, 4'd0, 8'd0);
	endtask

	task automatic test_directed_words();
		set_reg(REG_MASK, 32'h0000_8001);
		set_reg(REG_START, 32'h0000_0000);
		send_item(CMD_WRITE, 4'd0, 4'd15, 8'h00);
		send_item(CMD_WRITE, 4'd15, 4'd0, 8'hFF);
		send_item(CMD_WRITE, 4'd0, 4'd7, 8'hFF);
		send_item(CMD_WRITE, 4'd0, 4'd15, 8'hFF);
		send_item(CMD_FEED, 4'd0, 4'd0, 8'h00);
		send_item(CMD_END, 4'd0, 4'd0, 8'h00);
		send_item(CMD_FEED, 4'd15, 4'd15, 8'hFF);
		send_item(CMD_FEED, 4'd0, 4'd0, 8'hFF);
		send_item(CMD_END, 4'd15, 4'd15, 8'hFF);
		send_item(CMD_END, 4'd0, 4'd0, 8'h00);
		send_item(CMD_FEED, 4'd0, 4'd0, 8'h55);
		send_item(CMD_FEED, 4'd0, 4'd0, 8'h00);
		send_item(CMD_END, 4'd0, 4'd0, 8'h00);
		send_item(CMD_UNUSED, 4'd15, 4'd15, 8'hFF);
		send_item(CMD_UNUSED, 4'd0, 4'd0, 8'h00);
		send_item(CMD_FEED, 4'd0, 4'd0, 8'h00);
		send_item(CMD_FEED, 4'd0, 4'd0, 8'h42);
		set_reg(REG_START, 32'hFFFF_FFF0);
		send_item(CMD_END, 4'd0, 4'd0, 8'h00);
	endtask

	task automatic run_random_phase(logic [STATE_W-1:0] start_v, logic [MASK_W-1:0] mask_v,
			int n_writes, int n_words);
		logic [SYMBOL_BITS-1:0] alpha [4];
		logic [STATE_W-1:0]     f;
		logic [SYMBOL_BITS-1:0] s;
		logic [STATE_W-1:0]     st;
		int                     len;
		int                     noise;
		set_reg(REG_START, ($urandom() & 32'hFFFF_FFF0) | 32'(start_v));
		set_reg(REG_MASK, ($urandom() & 32'hFFFF_0000) | 32'(mask_v));
		foreach (alpha[i])
			alpha[i] = rand_symbol();
		repeat (n_writes) begin
			f = rand_state();
			s = ($urandom_range(0, 4) == 0) ? rand_symbol() : alpha[$urandom_range(0, 3)];
			send_item(CMD_WRITE, f, rand_state(), s);
			known_syms[f].push_back(s);
		end
		repeat (n_words) begin
			len = $urandom_range(0, 7);
			repeat (len) begin
				st    = cur_state;
				noise = $urandom_range(0, 19);
				if (noise == 0) begin
					send_item(CMD_UNUSED, rand_state(), rand_state(), rand_symbol());
				end else if (noise == 1) begin
					f = rand_state();
					s = rand_symbol();
					send_item(CMD_WRITE, f, rand_state(), s);
					known_syms[f].push_back(s);
				end
				if ($urandom_range(0, 9) != 0 && known_syms[st].size() != 0)
					s = known_syms[st][$urandom_range(0, known_syms[st].size() - 1)];
				else
					s = rand_symbol();
				send_item(CMD_FEED, rand_state(), rand_state(), s);
			end
			send_item(CMD_END, rand_state(), rand_state(), rand_symbol());
		end
	endtask

	task automatic test_random_automata();
		run_random_phase(4'd0, 16'h0000, 40, 40);
		run_random_phase(4'd15, 16'hFFFF, 40, 40);
		repeat (4)
			run_random_phase(rand_state(), MASK_W'($urandom_range(0, 16'hFFFF)), 40, 40);
	endtask

	task automatic test_result_stall();
		wait_drained();
		sink_hold = 400;
		repeat (150) begin
			if ($urandom_range(0, 2) == 0)
				send_item(CMD_FEED, rand_state(), rand_state(), rand_symbol());
			else
				send_item(CMD_END, rand_state(), rand_state(), rand_symbol());
		end
		wait_drained();
	endtask

	task automatic test_no_idle();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		run_random_phase(rand_state(), MASK_W'($urandom_range(0, 16'hFFFF)), 30, 50);
	endtask

	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		cmd        = CMD_WRITE;
		from_state = '0;
		to_state   = '0;
		symbol     = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			trans_valid[i] = 1'b0;
			trans_dest[i]  = '0;
		end
		cur_state = '0;
		start_reg = '0;
		mask_reg  = '0;
		word_dead = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_directed_words();
		test_random_automata();
		test_result_stall();
		test_no_idle();
		wait_drained();
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
sv/dfa_pkg.sv
sv/dfa_ram.sv
sv/dfa_front.sv
sv/dfa_back.sv
sv/dfa_word_recognizer.sv
bench/dfa_word_recognizer_test.sv
